@@ sv/dgp_pkg.sv @@
// shared types, codes and arithmetic helpers for the dpcm gap pixel predictor
// no dependencies; imported by the prediction pipeline, the top level and the testbench
`default_nettype none

package dgp_pkg;

    localparam int PIX_W      = 8;
    localparam int ERR_W      = 10;
    localparam int GRAD_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FW_BITS    = 11;
    localparam int FH_BITS    = 16;
    localparam int MODE_BITS  = 3;

    localparam int PRED_FIRST   = 128;
    localparam int GAP_T_SHARP  = 80;
    localparam int GAP_T_MED    = 32;
    localparam int GAP_T_SOFT   = 8;
    localparam int MIN_FW       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREDICT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // predict_mode codes
    localparam logic [MODE_BITS-1:0] MODE_NORTH = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_AVG   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_CALIC = 3'd4;

    typedef enum logic [1:0] {
        T_WEST  = 2'd0,
        T_OTHER = 2'd1,
        T_ERROR = 2'd2
    } t_tcode;

    // which predictor a pixel uses, decided from its position and the mode
    typedef enum logic [2:0] {
        SEL_FIRST = 3'd0,
        SEL_W     = 3'd1,
        SEL_N     = 3'd2,
        SEL_AVG   = 3'd3,
        SEL_GAP   = 3'd4
    } t_sel;

    // one pixel with its causal neighborhood, as it enters the pipeline
    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] w;
        logic [PIX_W-1:0] ww;
        logic [PIX_W-1:0] nw;
        logic [PIX_W-1:0] n;
        logic [PIX_W-1:0] ne;
        logic [PIX_W-1:0] nn;
        logic [PIX_W-1:0] nne;
        t_sel             sel;
        logic             last;
    } t_ctx;

    typedef struct packed {
        logic [PIX_W-1:0]        x;
        logic [PIX_W-1:0]        w;
        logic [PIX_W-1:0]        n;
        t_sel                    sel;
        logic                    last;
        logic [GRAD_W-1:0]       dh;
        logic [GRAD_W-1:0]       dv;
        logic signed [ERR_W-1:0] p;
        logic                    binary;
        logic                    has_other;
        logic [PIX_W-1:0]        other;
    } t_s1;

    typedef struct packed {
        logic [PIX_W-1:0]        x;
        logic signed [ERR_W-1:0] pred;
        t_tcode                  t;
        logic                    last;
    } t_s2;

    function automatic logic [PIX_W-1:0] absd(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // signed halving and quartering that truncate toward zero
    function automatic logic signed [11:0] sdiv2(input logic signed [11:0] a);
        logic signed [11:0] b;
        b = a + (a[11] ? 12'sd1 : 12'sd0);
        return b >>> 1;
    endfunction

    function automatic logic signed [11:0] sdiv4(input logic signed [11:0] a);
        logic signed [11:0] b;
        b = a + (a[11] ? 12'sd3 : 12'sd0);
        return b >>> 2;
    endfunction

endpackage

`default_nettype wire

@@ sv/dgp_line_ram.sv @@
// line store: one write port, two read ports, registered read data
// no dependencies; depth and width come from parameters
`default_nettype none

module dgp_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read, so a stalled pixel keeps its neighbors
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

@@ sv/dgp_pred_pipe.sv @@
// prediction pipeline: gradients and binary check, predictor select, error out
// depends on dgp_pkg
`default_nettype none

module dgp_pred_pipe (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire dgp_pkg::t_ctx                   i_ctx,
    output logic                                 o_ready,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [dgp_pkg::ERR_W-1:0]     o_pred_error,
    output logic        [1:0]                    o_t_code,
    output logic                                 o_frame_last
);
    import dgp_pkg::*;

    logic r_v1, r_v2, r_vo;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    logic signed [ERR_W-1:0] r_err;
    t_tcode r_t;
    logic   r_last;

    logic ready_o, ready2, ready1;

    assign ready_o = !r_vo || !i_stall;
    assign ready2  = !r_v2 || ready_o;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;

    // stage 1: gradients, base gap value, two-value check
    logic [PIX_W-1:0] nb [6];
    logic [5:0]       diff_w;
    logic             bin;
    logic [PIX_W-1:0] oth;
    logic signed [11:0] sp;

    always_comb begin
        nb[0] = i_ctx.ww;
        nb[1] = i_ctx.nw;
        nb[2] = i_ctx.n;
        nb[3] = i_ctx.ne;
        nb[4] = i_ctx.nn;
        nb[5] = i_ctx.nne;
        for (int i = 0; i < 6; i++) begin
            diff_w[i] = (nb[i] != i_ctx.w);
        end
        // binary when every pair that differs from w agrees
        bin = 1'b1;
        for (int i = 0; i < 6; i++) begin
            for (int j = i + 1; j < 6; j++) begin
                if (diff_w[i] && diff_w[j] && (nb[i] != nb[j])) begin
                    bin = 1'b0;
                end
            end
        end
        oth = i_ctx.w;
        for (int i = 5; i >= 0; i--) begin
            if (diff_w[i]) begin
                oth = nb[i];
            end
        end
        sp = $signed(12'(({2'b00, i_ctx.w} + {2'b00, i_ctx.n}) >> 1))
           + sdiv4($signed({4'b0000, i_ctx.ne}) - $signed({4'b0000, i_ctx.nw}));

        n_s1.x         = i_ctx.x;
        n_s1.w         = i_ctx.w;
        n_s1.n         = i_ctx.n;
        n_s1.sel       = i_ctx.sel;
        n_s1.last      = i_ctx.last;
        n_s1.dh        = GRAD_W'(absd(i_ctx.w, i_ctx.ww)) + GRAD_W'(absd(i_ctx.n, i_ctx.nw))
                       + GRAD_W'(absd(i_ctx.ne, i_ctx.n));
        n_s1.dv        = GRAD_W'(absd(i_ctx.w, i_ctx.nw)) + GRAD_W'(absd(i_ctx.n, i_ctx.nn))
                       + GRAD_W'(absd(i_ctx.ne, i_ctx.nne));
        n_s1.p         = sp[ERR_W-1:0];
        n_s1.binary    = bin;
        n_s1.has_other = |diff_w;
        n_s1.other     = oth;
    end

    // stage 2: gradient thresholds and predictor select
    logic signed [10:0] d;
    logic signed [11:0] p12, p3, hp, qp, w12, n12, gap, pr;
    t_tcode             tc;

    always_comb begin
        d   = $signed({1'b0, r_s1.dv}) - $signed({1'b0, r_s1.dh});
        p12 = {{(12-ERR_W){r_s1.p[ERR_W-1]}}, r_s1.p};
        p3  = p12 + (p12 <<< 1);
        hp  = sdiv2(p12);
        qp  = sdiv4(p3);
        w12 = $signed({4'b0000, r_s1.w});
        n12 = $signed({4'b0000, r_s1.n});

        if (d > GAP_T_SHARP) begin
            gap = w12;
        end else if (d < -GAP_T_SHARP) begin
            gap = n12;
        end else if (d > GAP_T_MED) begin
            gap = hp + (w12 >>> 1);
        end else if (d < -GAP_T_MED) begin
            gap = hp + (n12 >>> 1);
        end else if (d > GAP_T_SOFT) begin
            gap = qp + (w12 >>> 2);
        end else if (d < -GAP_T_SOFT) begin
            gap = qp + (n12 >>> 2);
        end else begin
            gap = p12;
        end

        tc = T_ERROR;
        case (r_s1.sel)
            SEL_FIRST: pr = 12'(PRED_FIRST);
            SEL_W:     pr = w12;
            SEL_N:     pr = n12;
            SEL_AVG:   pr = (w12 >>> 1) + (n12 >>> 1);
            SEL_GAP: begin
                pr = gap;
                if (r_s1.binary && (r_s1.x == r_s1.w)) begin
                    tc = T_WEST;
                end else if (r_s1.binary && r_s1.has_other && (r_s1.x == r_s1.other)) begin
                    tc = T_OTHER;
                end
            end
            default:   pr = w12;
        endcase

        n_s2.x    = r_s1.x;
        n_s2.pred = pr[ERR_W-1:0];
        n_s2.t    = tc;
        n_s2.last = r_s1.last;
    end

    logic signed [ERR_W:0] err;
    assign err = $signed({3'b000, r_s2.x}) - $signed({r_s2.pred[ERR_W-1], r_s2.pred});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_load;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_load) begin
            r_s1 <= n_s1;
        end
        if (ready2) begin
            r_s2 <= n_s2;
        end
        if (ready_o) begin
            r_err  <= (r_s2.t == T_ERROR) ? err[ERR_W-1:0] : '0;
            r_t    <= r_s2.t;
            r_last <= r_s2.last;
        end
    end

    assign o_valid      = r_vo;
    assign o_pred_error = r_err;
    assign o_t_code     = r_t;
    assign o_frame_last = r_last;

endmodule

`default_nettype wire

@@ sv/dpcm_gap_pixel_predictor.sv @@
// top level: configuration, raster counters, line stores and the prediction pipeline
// depends on dgp_pkg, dgp_line_ram and dgp_pred_pipe
`default_nettype none

// Takes one 8-bit grayscale pixel per beat in raster order and returns one beat per
// pixel with its prediction error, the t code and a frame-last flag. A new pixel
// is taken every clock while the result side does not stall; each pixel passes
// the gradient stage, the predictor stage and the output register on its way to its result beat. The north and
// north-north rows live in two line stores of MAX_WIDTH entries, each read at two
// columns and written at one per pixel; the neighbors of the next pixel are
// fetched at the edge that takes the current one, so the stores never need
// clearing and the first rows of a frame fall back to the boundary predictors.
// Configuration is to be written by the user only while the block is idle, which the
// block itself does not enforce; a write takes effect on the next pixel.
module dpcm_gap_pixel_predictor #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [dgp_pkg::PIX_W-1:0]            i_pixel_value,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [dgp_pkg::ERR_W-1:0]          o_pred_error,
    output logic        [1:0]                         o_t_code,
    output logic                                      o_frame_last,
    input  wire logic                                 i_cfg_we,
    input  wire logic [dgp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [dgp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dgp_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RST_FW = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam logic [CW-1:0] COL_MAX = CW'(MAX_WIDTH - 1);

    logic [MODE_BITS-1:0] r_mode;
    logic [CW-1:0]        r_last_col, n_last_col;
    logic [FH_BITS-1:0]   r_last_row;
    logic [FW_BITS-1:0]   cfg_fw;
    logic [FH_BITS-1:0]   cfg_fh;

    assign cfg_fw = i_cfg_data[FW_BITS-1:0];
    assign cfg_fh = i_cfg_data[FH_BITS-1:0];

    always_comb begin
        if (cfg_fw < FW_BITS'(MIN_FW)) begin
            n_last_col = CW'(MIN_FW - 1);
        end else if (32'(cfg_fw) > MAX_WIDTH) begin
            n_last_col = COL_MAX;
        end else begin
            n_last_col = CW'(cfg_fw - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CALIC;
            r_last_col <= CW'(RST_FW - 1);
            r_last_row <= FH_BITS'(1023);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREDICT_MODE: r_mode     <= i_cfg_data[MODE_BITS-1:0];
                CFG_FRAME_WIDTH:  r_last_col <= n_last_col;
                CFG_FRAME_HEIGHT: r_last_row <= (cfg_fh == '0) ? '0 : cfg_fh - 1'b1;
                default: ;
            endcase
        end
    end

    // raster position and the west-side pixel registers
    logic [CW-1:0]      r_col, nxt_col, nxt_ne;
    logic [FH_BITS-1:0] r_row;
    logic [PIX_W-1:0]   r_w, r_ww, r_nw;
    logic               r_ne_ok;
    logic               last_col, last_row, acc, pipe_ready;
    logic [PIX_W-1:0]   n_rd0, n_rd1, nn_rd0, nn_rd1;
    t_sel               sel;
    t_ctx               ctx;

    assign last_col = (r_col >= r_last_col);
    assign last_row = (r_row >= r_last_row);
    assign nxt_col  = last_col ? '0 : r_col + 1'b1;
    assign nxt_ne   = nxt_col + 1'b1;
    assign acc      = i_valid && pipe_ready;
    assign o_stall  = !pipe_ready;

    always_comb begin
        if (r_row == '0) begin
            sel = (r_col == '0) ? SEL_FIRST : SEL_W;
        end else if (r_row == FH_BITS'(1) || r_col < CW'(2) || last_col) begin
            sel = SEL_N;
        end else begin
            case (r_mode)
                MODE_NORTH: sel = SEL_N;
                MODE_AVG:   sel = SEL_AVG;
                MODE_CALIC: sel = SEL_GAP;
                default:    sel = SEL_W;
            endcase
        end
    end

    always_comb begin
        ctx.x    = i_pixel_value;
        ctx.w    = r_w;
        ctx.ww   = r_ww;
        ctx.nw   = r_nw;
        ctx.n    = n_rd0;
        ctx.nn   = nn_rd0;
        ctx.ne   = r_ne_ok ? n_rd1 : '0;
        ctx.nne  = r_ne_ok ? nn_rd1 : '0;
        ctx.sel  = sel;
        ctx.last = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_w     <= '0;
            r_ww    <= '0;
            r_nw    <= '0;
            r_ne_ok <= 1'b1;
        end else if (acc) begin
            r_col   <= nxt_col;
            if (last_col) begin
                r_row <= last_row ? '0 : r_row + 1'b1;
            end
            r_w     <= i_pixel_value;
            r_ww    <= r_w;
            r_nw    <= n_rd0;
            r_ne_ok <= (nxt_col != COL_MAX);
        end
    end

    // the current column is rewritten while the next pixel's columns are fetched
    dgp_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_north_ram (
        .i_clk    (i_clk),
        .i_we     (acc),
        .i_waddr  (r_col),
        .i_wdata  (i_pixel_value),
        .i_re     (acc),
        .i_raddr0 (nxt_col),
        .i_raddr1 (nxt_ne),
        .o_rdata0 (n_rd0),
        .o_rdata1 (n_rd1)
    );

    dgp_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_nnorth_ram (
        .i_clk    (i_clk),
        .i_we     (acc),
        .i_waddr  (r_col),
        .i_wdata  (n_rd0),
        .i_re     (acc),
        .i_raddr0 (nxt_col),
        .i_raddr1 (nxt_ne),
        .o_rdata0 (nn_rd0),
        .o_rdata1 (nn_rd1)
    );

    dgp_pred_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (acc),
        .i_ctx        (ctx),
        .o_ready      (pipe_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pred_error (o_pred_error),
        .o_t_code     (o_t_code),
        .o_frame_last (o_frame_last)
    );

    // no read of the next pixel's columns may hit the column being written
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> (nxt_col != r_col) && (nxt_ne != r_col))
        else $error("line store read collides with write");

    // an empty output register means the whole pipeline can take a pixel
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // binary-mode results carry no error
    a_binary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_t_code != T_ERROR)) |-> (o_pred_error == '0))
        else $error("nonzero error on binary code");

    // a frame-last beat is followed by a first-of-frame fetch state
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last_col && last_row) |=> (r_col == '0) && (r_row == '0))
        else $error("counters did not wrap at frame end");

endmodule

`default_nettype wire

@@ tb/sv/tb_dpcm_gap_pixel_predictor.sv @@
// self-checking testbench for dpcm_gap_pixel_predictor: raster frames in, residual beats out
// carries its own model of the line stores and predictors; needs dgp_pkg and the block rtl
`timescale 1ns / 100ps

module tb_dpcm_gap_pixel_predictor;
    import dgp_pkg::*;

    localparam int LINE_MAX      = 1024;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PIXELS = 480;
    localparam int HOLD_CYCLES   = 64;
    localparam int HOLD_SPACING  = 700;
    localparam logic [MODE_BITS-1:0] MODE_WEST = 3'd1;

    typedef enum {TEX_NOISE, TEX_BINARY, TEX_FLAT, TEX_RAMP, TEX_STRIPES} t_texture;

    typedef struct {
        logic [ERR_W-1:0] err;
        t_tcode           t;
        logic             last;
    } t_residual;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic [PIX_W-1:0]        in_pixel = '0;
    logic                    px_stall;
    logic                    out_valid;
    logic                    rx_stall = 1'b0;
    logic signed [ERR_W-1:0] out_err;
    logic [1:0]              out_t;
    logic                    out_last;
    logic                    cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx  = CFG_PREDICT_MODE;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // model state: configuration, line stores, neighbors and raster position
    logic [MODE_BITS-1:0] cfg_mode   = MODE_CALIC;
    logic [FW_BITS-1:0]   cfg_width  = 11'd1024;
    logic [FH_BITS-1:0]   cfg_height = 16'd1024;
    logic [PIX_W-1:0]     north_line  [LINE_MAX];
    logic [PIX_W-1:0]     north2_line [LINE_MAX];
    int west_pix  = 0;
    int west2_pix = 0;
    int nw_held   = 0;
    int col_cnt   = 0;
    int row_cnt   = 0;

    logic [PIX_W-1:0] raster_pixels[$];
    t_residual        expected_residuals[$];

    int pix_sent      = 0;
    int pix_taken     = 0;
    int rx_beats      = 0;
    int rx_seen       = 0;
    int mismatches    = 0;
    int cycles        = 0;
    int pixels_queued = 0;
    int phase_no      = 0;
    int tx_gap        = 0;
    int rx_wait       = 0;
    int hold_left     = 0;
    int next_hold_at  = 200;
    bit tx_burst      = 1'b0;
    bit rx_burst      = 1'b0;

    // 4 x 6 frame: extremes, single-value and two-value neighborhoods, escape to gap
    logic [PIX_W-1:0] corner_frame [24] = '{
          0, 255, 200, 200,
         17, 200, 200, 200,
        200, 200, 200, 200,
        200,  90, 200,  90,
         90, 200,   5, 255,
        255, 255,   0,   0
    };

    dpcm_gap_pixel_predictor #(.MAX_WIDTH(LINE_MAX)) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (px_stall),
        .i_pixel_value (in_pixel),
        .o_valid       (out_valid),
        .i_stall       (rx_stall),
        .o_pred_error  (out_err),
        .o_t_code      (out_t),
        .o_frame_last  (out_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int adiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int eff_width();
        int ew;
        ew = cfg_width;
        if (ew < MIN_FW) ew = MIN_FW;
        if (ew > LINE_MAX) ew = LINE_MAX;
        return ew;
    endfunction

    function automatic int eff_height();
        return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    function automatic int gap_estimate(int w, int ww, int nw, int n, int ne, int nn, int nne);
        int dh, dv, p;
        dh = adiff(w, ww) + adiff(n, nw) + adiff(ne, n);
        dv = adiff(w, nw) + adiff(n, nn) + adiff(ne, nne);
        if (dv - dh > GAP_T_SHARP) return w;
        if (dh - dv > GAP_T_SHARP) return n;
        p = (w + n) / 2 + (ne - nw) / 4;
        if (dv - dh > GAP_T_MED)       p = p / 2 + w / 2;
        else if (dh - dv > GAP_T_MED)  p = p / 2 + n / 2;
        else if (dv - dh > GAP_T_SOFT) p = (3 * p) / 4 + w / 4;
        else if (dh - dv > GAP_T_SOFT) p = (3 * p) / 4 + n / 4;
        return p;
    endfunction

    // works out the residual of one accepted pixel and advances the raster state
    task automatic predict_residual(input logic [PIX_W-1:0] px);
        int ew, eh, c, r, x, w, ww, nw, n, nn, ne, nne, pred, other, k;
        int hood [7];
        bit last_col, last_row, binary, has_other;
        t_tcode t;
        t_residual res;
        ew = eff_width();
        eh = eff_height();
        c = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
        r = row_cnt;
        x = px;
        w = west_pix;
        ww = west2_pix;
        nw = nw_held;
        last_col = (c >= ew - 1);
        last_row = (r >= eh - 1);
        n = north_line[c];
        nn = north2_line[c];
        ne = 0;
        nne = 0;
        if (c + 1 < LINE_MAX) begin
            ne = north_line[c + 1];
            nne = north2_line[c + 1];
        end
        pred = 0;
        t = T_ERROR;
        if (r == 0) begin
            pred = (c == 0) ? PRED_FIRST : w;
        end else if (r == 1 || c < 2 || last_col) begin
            pred = n;
        end else if (cfg_mode == MODE_NORTH) begin
            pred = n;
        end else if (cfg_mode == MODE_AVG) begin
            pred = w / 2 + n / 2;
        end else if (cfg_mode == MODE_CALIC) begin
            hood = '{w, ww, nw, n, ne, nn, nne};
            other = w;
            has_other = 1'b0;
            binary = 1'b1;
            for (k = 1; k < 7; k++) begin
                if (hood[k] != w) begin
                    if (!has_other) begin
                        has_other = 1'b1;
                        other = hood[k];
                    end else if (hood[k] != other) begin
                        binary = 1'b0;
                    end
                end
            end
            if (binary && x == w) t = T_WEST;
            else if (binary && has_other && x == other) t = T_OTHER;
            else pred = gap_estimate(w, ww, nw, n, ne, nn, nne);
        end else begin
            pred = w;
        end
        res.err = (t == T_ERROR) ? ERR_W'(x - pred) : '0;
        res.t = t;
        res.last = last_col && last_row;
        expected_residuals.push_back(res);
        nw_held = n;
        north2_line[c] = PIX_W'(n);
        north_line[c] = px;
        west2_pix = west_pix;
        west_pix = x;
        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_cnt = c + 1;
        end
    endtask

    function automatic int pixels_left_in_frame();
        int ew, eh, c, r;
        ew = eff_width();
        eh = eff_height();
        c = (col_cnt >= ew - 1) ? ew - 1 : col_cnt;
        r = (row_cnt >= eh - 1) ? eh - 1 : row_cnt;
        return (ew - c) + (eh - 1 - r) * ew;
    endfunction

    function automatic logic [PIX_W-1:0] texel(t_texture tx, int c, int r,
                                               int k0, int k1, int k2, int k3);
        int v, roll;
        roll = $urandom_range(0, 19);
        case (tx)
            TEX_BINARY: begin
                v = ((((c / k2) + (r / k2)) % 2) != 0) ? k0 : k1;
                if (roll == 0) v = $urandom_range(0, 255);
                else if (roll == 1) v = (v == k0) ? k1 : k0;
            end
            TEX_FLAT: v = (roll < 2) ? int'($urandom_range(0, 255)) : k0;
            TEX_RAMP: v = k0 + c * k1 + r * k2 + int'($urandom_range(0, k3));
            TEX_STRIPES: begin
                v = ((((k3 != 0) ? c : r) % k2) < k2 / 2) ? k0 : k1;
                if (roll == 0) v = $urandom_range(0, 255);
            end
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    // queues raster positions first .. first+count-1 of the current geometry
    task automatic push_pixels(input t_texture tx, input int first, input int count);
        int ew, k, k0, k1, k2, k3;
        ew = eff_width();
        k0 = $urandom_range(0, 255);
        k1 = $urandom_range(0, 255);
        k2 = 1;
        k3 = 0;
        case (tx)
            TEX_BINARY: begin
                if ($urandom_range(0, 3) == 0) begin
                    k0 = 0;
                    k1 = 255;
                end
                k2 = $urandom_range(1, 3);
            end
            TEX_RAMP: begin
                k1 = int'($urandom_range(0, 80)) - 40;
                k2 = int'($urandom_range(0, 80)) - 40;
                k3 = $urandom_range(0, 6);
            end
            TEX_STRIPES: begin
                k2 = $urandom_range(2, 6);
                k3 = $urandom_range(0, 1);
            end
            default: ;
        endcase
        for (k = first; k < first + count; k++) begin
            raster_pixels.push_back(texel(tx, k % ew, k / ew, k0, k1, k2, k3));
            pixels_queued++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            CFG_PREDICT_MODE: cfg_mode = MODE_BITS'(value);
            CFG_FRAME_WIDTH:  cfg_width = FW_BITS'(value);
            CFG_FRAME_HEIGHT: cfg_height = FH_BITS'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [MODE_BITS-1:0] mode, input int width,
                                input int height);
        write_reg(CFG_PREDICT_MODE, mode);
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
    endtask

    task automatic wait_idle();
        while (raster_pixels.size() != 0 || pix_taken != pix_sent ||
               expected_residuals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // whole frames under random settings; the first eight sweep every mode code
    task automatic random_frames(input int target);
        int start, width, height, frames, f;
        logic [MODE_BITS-1:0] mode;
        start = pixels_queued;
        while (pixels_queued - start < target) begin
            if (phase_no < 8) mode = MODE_BITS'(phase_no);
            else if ($urandom_range(0, 3) == 0) mode = MODE_BITS'($urandom_range(0, 7));
            else mode = MODE_CALIC;
            phase_no++;
            case ($urandom_range(0, 19))
                0, 1:    width = $urandom_range(0, 2);
                2, 3, 4: width = $urandom_range(13, 40);
                default: width = $urandom_range(3, 12);
            endcase
            if ($urandom_range(0, 9) == 0) height = 0;
            else height = (width > 12) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            set_geometry(mode, width, height);
            frames = $urandom_range(1, 2);
            for (f = 0; f < frames; f++)
                push_pixels(t_texture'($urandom_range(0, 4)), 0, eff_width() * eff_height());
            wait_idle();
        end
    endtask

    // pixel beat source
    always @(negedge clk) begin : pixel_driver
        logic offer;
        offer = in_valid;
        if (rst_n && pix_taken == pix_sent) begin
            if (tx_gap > 0) begin
                tx_gap--;
                offer = 1'b0;
            end else if (raster_pixels.size() != 0) begin
                in_pixel <= raster_pixels.pop_front();
                offer = 1'b1;
                pix_sent++;
                if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 5);
            end else begin
                offer = 1'b0;
            end
        end
        in_valid <= offer;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !px_stall) begin
            predict_residual(in_pixel);
            pix_taken++;
        end
    end

    // result side backpressure, with a long hold every so often to fill the pipe
    always @(negedge clk) begin : result_stall
        logic hold;
        if (rx_beats != rx_seen) begin
            rx_seen = rx_beats;
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
        end
        // only start a hold while the source still has pixels to push
        if (hold_left == 0 && rx_beats >= next_hold_at && raster_pixels.size() > 8) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += HOLD_SPACING;
        end
        if (hold_left > 0) begin
            hold_left--;
            hold = 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            hold = 1'b1;
        end else begin
            hold = 1'b0;
        end
        rx_stall <= hold;
    end

    always @(posedge clk) begin : result_check
        t_residual want;
        if (rst_n && out_valid && !rx_stall) begin
            rx_beats++;
            if (expected_residuals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d with nothing pending: err %0d t %0d last %0d",
                             rx_beats, out_err, out_t, out_last);
            end else begin
                want = expected_residuals.pop_front();
                if (out_err !== want.err || out_t !== want.t || out_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d: want err %0d t %0d last %0d, ",
                                  "got err %0d t %0d last %0d"},
                                 rx_beats, $signed(want.err), want.t, want.last,
                                 out_err, out_t, out_last);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_dpcm_gap_pixel_predictor: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        for (k = 0; k < LINE_MAX; k++) begin
            north_line[k] = '0;
            north2_line[k] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_geometry(MODE_CALIC, 4, 6);
        foreach (corner_frame[i]) begin
            raster_pixels.push_back(corner_frame[i]);
            pixels_queued++;
        end
        wait_idle();

        random_frames(RANDOM_PIXELS / 2);

        // mode switched halfway through a frame
        set_geometry(MODE_CALIC, 6, 6);
        push_pixels(TEX_BINARY, 0, 20);
        wait_idle();
        write_reg(CFG_PREDICT_MODE, MODE_AVG);
        push_pixels(TEX_RAMP, 20, pixels_left_in_frame());
        wait_idle();

        // width above the line store size clamps, then the row is narrowed to an end still ahead of the counter
        set_geometry(MODE_WEST, 2047, 1);
        push_pixels(TEX_NOISE, 0, 40);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 48);
        push_pixels(TEX_NOISE, 40, pixels_left_in_frame());
        wait_idle();

        // tallest frame, cut short by shrinking both sizes behind the counters
        set_geometry(MODE_CALIC, 7, 65535);
        push_pixels(TEX_STRIPES, 0, 33);
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, 2);
        write_reg(CFG_FRAME_WIDTH, 4);
        push_pixels(TEX_NOISE, 0, pixels_left_in_frame());
        wait_idle();

        random_frames(RANDOM_PIXELS - RANDOM_PIXELS / 2);

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_dpcm_gap_pixel_predictor: done, clean");
        else
            $display("tb_dpcm_gap_pixel_predictor: done, errors");
        $finish;
    end

endmodule
